FILE: hdl/ray_sphere_intersect_macros.svh
// Assertion helpers for the checker file rsi_checker.sv.
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSI_ASSERT_IMP(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSI_ASSERT_NEXT(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hdl/rsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

    localparam int FRAC_BITS = 16;

    localparam int COORD_W  = 32;
    localparam int RAD_W    = 31;
    localparam int OC_W     = COORD_W + 1;
    localparam int DD_W     = 2 * COORD_W;
    localparam int SQ_DIR_W = DD_W - 1;
    localparam int OD_W     = OC_W + COORD_W;
    localparam int OO_W     = 2 * OC_W;
    localparam int RR_W     = 2 * RAD_W;
    localparam int A_W      = 64;
    localparam int HB_W     = 67;
    localparam int C_W      = 67;
    localparam int HBM_W    = HB_W - 1;
    localparam int CM_W     = C_W - 1;
    localparam int HALF_W   = 33;
    localparam int PP_W     = 2 * HALF_W;
    localparam int HB2_W    = 2 * HBM_W;
    localparam int AC_W     = A_W + CM_W;
    localparam int DISC_W   = 134;
    localparam int ROOT_W   = DISC_W / 2;
    localparam int SQ_REM_W = ROOT_W + 3;
    localparam int SUM_W    = HB_W + 2;
    localparam int MAG_W    = SUM_W - 1;
    localparam int M_W      = MAG_W + FRAC_BITS;
    localparam int Q_W      = 32;
    localparam int HI_W     = M_W - Q_W;
    localparam int DIST_W   = 32;

    localparam logic [DIST_W-1:0] MINUS_ONE = DIST_W'(0) - (DIST_W'(1) << FRAC_BITS);
    localparam logic [DIST_W-1:0] DIST_MAX  = 32'h7FFF_FFFF;
    localparam logic [DIST_W-1:0] DIST_MIN  = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_MISS     = 2'd1,
        ST_ZERO_DIR = 2'd2
    } status_t;

    typedef struct packed {
        logic    vld;
        status_t status;
    } rsi_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/ray_sphere_intersect.sv
// Ray / sphere intersection engine, signed fixed point (rsi_pkg::FRAC_BITS fraction bits).
// Input channel (ray_valid / ray_stall): one word holds a ray origin, direction,
// sphere center and radius. Output channel (res_valid / res_stall): one word per
// input word, in order, with hit_status (hit, miss, zero direction), the nearer
// root hit_distance (floored, saturated, -1.0 when not hit) and distance_saturated.
// Pipeline, from acceptance to res_valid: dot products, the discriminant formed
// from split 33-bit partial products, square root (one root bit per stage),
// numerator, overflow check, 32 quotient-bit stages and floor/saturate.
// Throughput: one word per cycle while the pipe is not stalled; every stage is
// a register, so a new ray may enter each cycle while up to 110 are in flight.
// Stall: when a finished word sits on the output and res_stall is high, the
// whole pipe holds and ray_stall rises in the same cycle; nothing is dropped.
// Reset (rst_n low, async) clears every valid bit; the pipe comes up empty
// and ready.
`timescale 1ns / 1ps
`default_nettype none

module ray_sphere_intersect (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               ray_valid,
    output logic                                    ray_stall,
    input  wire logic signed [rsi_pkg::COORD_W-1:0] origin_x,
    input  wire logic signed [rsi_pkg::COORD_W-1:0] origin_y,
    input  wire logic signed [rsi_pkg::COORD_W-1:0] origin_z,
    input  wire logic signed [rsi_pkg::COORD_W-1:0] dir_x,
    input  wire logic signed [rsi_pkg::COORD_W-1:0] dir_y,
    input  wire logic signed [rsi_pkg::COORD_W-1:0] dir_z,
    input  wire logic signed [rsi_pkg::COORD_W-1:0] center_x,
    input  wire logic signed [rsi_pkg::COORD_W-1:0] center_y,
    input  wire logic signed [rsi_pkg::COORD_W-1:0] center_z,
    input  wire logic        [rsi_pkg::RAD_W-1:0]   sphere_radius,
    output logic                                    res_valid,
    input  wire logic                               res_stall,
    output logic             [1:0]                  hit_status,
    output logic signed      [rsi_pkg::DIST_W-1:0]  hit_distance,
    output logic                                    distance_saturated
);
    import rsi_pkg::*;

    // global advance: hold everything while the output word is not taken
    logic adv;

    rsi_ctl_t               fr_ctl;
    logic [A_W-1:0]         fr_a;
    logic signed [HB_W-1:0] fr_hb;
    logic signed [C_W-1:0]  fr_c;

    rsi_ctl_t               ds_ctl;
    logic [DISC_W-1:0]      ds_disc;
    logic signed [HB_W-1:0] ds_hb;
    logic [A_W-1:0]         ds_a;

    rsi_ctl_t               sq_ctl;
    logic [ROOT_W-1:0]      sq_root;
    logic signed [HB_W-1:0] sq_hb;
    logic [A_W-1:0]         sq_a;

    assign adv       = !(res_valid && res_stall);
    assign ray_stall = !adv;

    // oc, |dir|^2, oc.dir, |oc|^2 - r^2
    rsi_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_vld        (ray_valid),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .origin_z      (origin_z),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .dir_z         (dir_z),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .sphere_radius (sphere_radius),
        .ctl           (fr_ctl),
        .a             (fr_a),
        .hb            (fr_hb),
        .c             (fr_c)
    );

    // disc = hb^2 - a*c, classify zero direction and miss
    rsi_disc u_disc (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .ctl_in (fr_ctl),
        .a_in   (fr_a),
        .hb_in  (fr_hb),
        .c_in   (fr_c),
        .ctl    (ds_ctl),
        .disc   (ds_disc),
        .hb     (ds_hb),
        .a      (ds_a)
    );

    // floor(sqrt(disc)), one bit per stage
    rsi_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .ctl_in  (ds_ctl),
        .disc_in (ds_disc),
        .hb_in   (ds_hb),
        .a_in    (ds_a),
        .ctl     (sq_ctl),
        .root    (sq_root),
        .hb      (sq_hb),
        .a       (sq_a)
    );

    // t = floor((-hb - s) * 2^F / a), saturated; output register lives here
    rsi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .ctl_in   (sq_ctl),
        .root_in  (sq_root),
        .hb_in    (sq_hb),
        .a_in     (sq_a),
        .res_vld  (res_valid),
        .status   (hit_status),
        .hit_dist (hit_distance),
        .sat      (distance_saturated)
    );

endmodule

`default_nettype wire

FILE: hdl/rsi_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rsi_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               adv,
    input  wire logic                               in_vld,
    input  wire logic signed [rsi_pkg::COORD_W-1:0] origin_x,
    input  wire logic signed [rsi_pkg::COORD_W-1:0] origin_y,
    input  wire logic signed [rsi_pkg::COORD_W-1:0] origin_z,
    input  wire logic signed [rsi_pkg::COORD_W-1:0] dir_x,
    input  wire logic signed [rsi_pkg::COORD_W-1:0] dir_y,
    input  wire logic signed [rsi_pkg::COORD_W-1:0] dir_z,
    input  wire logic signed [rsi_pkg::COORD_W-1:0] center_x,
    input  wire logic signed [rsi_pkg::COORD_W-1:0] center_y,
    input  wire logic signed [rsi_pkg::COORD_W-1:0] center_z,
    input  wire logic        [rsi_pkg::RAD_W-1:0]   sphere_radius,
    output rsi_pkg::rsi_ctl_t                       ctl,
    output logic             [rsi_pkg::A_W-1:0]     a,
    output logic signed      [rsi_pkg::HB_W-1:0]    hb,
    output logic signed      [rsi_pkg::C_W-1:0]     c
);
    import rsi_pkg::*;

    // stage 1: oc = origin - center
    logic                      vld1_reg;
    logic signed [OC_W-1:0]    oc_next [3];
    logic signed [OC_W-1:0]    oc_reg [3];
    logic signed [COORD_W-1:0] dir_reg [3];
    logic        [RAD_W-1:0]   rad_reg;

    // stage 2: products
    logic                      vld2_reg;
    logic signed [DD_W-1:0]    dd_next [3];
    logic signed [OD_W-1:0]    od_next [3];
    logic signed [OO_W-1:0]    oo_next [3];
    logic        [RR_W-1:0]    rr_next;
    logic        [SQ_DIR_W-1:0] dd_reg [3];
    logic signed [OD_W-1:0]    od_reg [3];
    logic signed [OO_W-1:0]    oo_reg [3];
    logic        [RR_W-1:0]    rr_reg;

    // stage 3: sums
    logic                      vld3_reg;
    logic        [A_W-1:0]     a_next;
    logic signed [HB_W-1:0]    hb_next;
    logic signed [C_W-1:0]     c_next;
    logic        [A_W-1:0]     a_reg;
    logic signed [HB_W-1:0]    hb_reg;
    logic signed [C_W-1:0]     c_reg;

    always_comb
    begin
        oc_next[0] = OC_W'(origin_x) - OC_W'(center_x);
        oc_next[1] = OC_W'(origin_y) - OC_W'(center_y);
        oc_next[2] = OC_W'(origin_z) - OC_W'(center_z);
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dd_next[k] = dir_reg[k] * dir_reg[k];
            od_next[k] = oc_reg[k] * dir_reg[k];
            oo_next[k] = oc_reg[k] * oc_reg[k];
        end
        rr_next = RR_W'(rad_reg) * RR_W'(rad_reg);
    end

    always_comb
    begin
        a_next  = A_W'(dd_reg[0]) + A_W'(dd_reg[1]) + A_W'(dd_reg[2]);
        hb_next = HB_W'(od_reg[0]) + HB_W'(od_reg[1]) + HB_W'(od_reg[2]);
        c_next  = C_W'(oo_reg[0]) + C_W'(oo_reg[1]) + C_W'(oo_reg[2])
                - $signed(C_W'(rr_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            oc_reg     <= oc_next;
            dir_reg[0] <= dir_x;
            dir_reg[1] <= dir_y;
            dir_reg[2] <= dir_z;
            rad_reg    <= sphere_radius;
            for (int k = 0; k < 3; k++)
            begin
                dd_reg[k] <= dd_next[k][SQ_DIR_W-1:0];
                od_reg[k] <= od_next[k];
                oo_reg[k] <= oo_next[k];
            end
            rr_reg <= rr_next;
            a_reg  <= a_next;
            hb_reg <= hb_next;
            c_reg  <= c_next;
        end
    end

    assign ctl = '{vld: vld3_reg, status: ST_HIT};
    assign a   = a_reg;
    assign hb  = hb_reg;
    assign c   = c_reg;

endmodule

`default_nettype wire

FILE: hdl/rsi_disc.sv
`timescale 1ns / 1ps
`default_nettype none

module rsi_disc (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            adv,
    input  rsi_pkg::rsi_ctl_t                    ctl_in,
    input  wire logic        [rsi_pkg::A_W-1:0]  a_in,
    input  wire logic signed [rsi_pkg::HB_W-1:0] hb_in,
    input  wire logic signed [rsi_pkg::C_W-1:0]  c_in,
    output rsi_pkg::rsi_ctl_t                    ctl,
    output logic        [rsi_pkg::DISC_W-1:0]    disc,
    output logic signed [rsi_pkg::HB_W-1:0]      hb,
    output logic        [rsi_pkg::A_W-1:0]       a
);
    import rsi_pkg::*;

    // stage 4: magnitudes
    logic                   vld4_reg;
    logic [HBM_W-1:0]       hbm_reg;
    logic [CM_W-1:0]        cm_reg;
    logic                   cneg4_reg;
    logic                   azero4_reg;
    logic [A_W-1:0]         a4_reg;
    logic signed [HB_W-1:0] hb4_reg;

    // stage 5: partial products
    logic                   vld5_reg;
    logic [PP_W-1:0]        hh11_next, hh10_next, hh00_next;
    logic [PP_W-1:0]        ac11_next, ac10_next, ac01_next, ac00_next;
    logic [PP_W-1:0]        hh11_reg, hh10_reg, hh00_reg;
    logic [PP_W-1:0]        ac11_reg, ac10_reg, ac01_reg, ac00_reg;
    logic                   cneg5_reg;
    logic                   azero5_reg;
    logic [A_W-1:0]         a5_reg;
    logic signed [HB_W-1:0] hb5_reg;

    // stage 6: full products
    logic                   vld6_reg;
    logic [HB2_W-1:0]       hb2_next, hb2_reg;
    logic [AC_W-1:0]        ac_next, ac_reg;
    logic                   cneg6_reg;
    logic                   azero6_reg;
    logic [A_W-1:0]         a6_reg;
    logic signed [HB_W-1:0] hb6_reg;

    // stage 7: discriminant and status
    logic [DISC_W-1:0]      disc_next, disc_reg;
    rsi_ctl_t               ctl7_next, ctl7_reg;
    logic [A_W-1:0]         a7_reg;
    logic signed [HB_W-1:0] hb7_reg;

    always_comb
    begin
        hh11_next = PP_W'(hbm_reg[HBM_W-1:HALF_W]) * PP_W'(hbm_reg[HBM_W-1:HALF_W]);
        hh10_next = PP_W'(hbm_reg[HBM_W-1:HALF_W]) * PP_W'(hbm_reg[HALF_W-1:0]);
        hh00_next = PP_W'(hbm_reg[HALF_W-1:0]) * PP_W'(hbm_reg[HALF_W-1:0]);
        ac11_next = PP_W'(a4_reg[A_W-1:HALF_W]) * PP_W'(cm_reg[CM_W-1:HALF_W]);
        ac10_next = PP_W'(a4_reg[A_W-1:HALF_W]) * PP_W'(cm_reg[HALF_W-1:0]);
        ac01_next = PP_W'(a4_reg[HALF_W-1:0]) * PP_W'(cm_reg[CM_W-1:HALF_W]);
        ac00_next = PP_W'(a4_reg[HALF_W-1:0]) * PP_W'(cm_reg[HALF_W-1:0]);
    end

    always_comb
    begin
        hb2_next = (HB2_W'(hh11_reg) << (2 * HALF_W))
                 + (HB2_W'(hh10_reg) << (HALF_W + 1))
                 + HB2_W'(hh00_reg);
        ac_next  = (AC_W'(ac11_reg) << (2 * HALF_W))
                 + (AC_W'(ac10_reg) << HALF_W)
                 + (AC_W'(ac01_reg) << HALF_W)
                 + AC_W'(ac00_reg);
    end

    always_comb
    begin
        if (cneg6_reg)
            disc_next = DISC_W'(hb2_reg) + DISC_W'(ac_reg);
        else
            disc_next = DISC_W'(hb2_reg) - DISC_W'(ac_reg);
        ctl7_next.vld = vld6_reg;
        priority if (azero6_reg)
            ctl7_next.status = ST_ZERO_DIR;
        else if (disc_next[DISC_W-1])
            ctl7_next.status = ST_MISS;
        else
            ctl7_next.status = ST_HIT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
            ctl7_reg <= '0;
        end
        else if (adv)
        begin
            vld4_reg <= ctl_in.vld;
            vld5_reg <= vld4_reg;
            vld6_reg <= vld5_reg;
            ctl7_reg <= ctl7_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hbm_reg    <= HBM_W'(hb_in[HB_W-1] ? -hb_in : hb_in);
            cm_reg     <= CM_W'(c_in[C_W-1] ? -c_in : c_in);
            cneg4_reg  <= c_in[C_W-1];
            azero4_reg <= (a_in == '0);
            a4_reg     <= a_in;
            hb4_reg    <= hb_in;

            hh11_reg   <= hh11_next;
            hh10_reg   <= hh10_next;
            hh00_reg   <= hh00_next;
            ac11_reg   <= ac11_next;
            ac10_reg   <= ac10_next;
            ac01_reg   <= ac01_next;
            ac00_reg   <= ac00_next;
            cneg5_reg  <= cneg4_reg;
            azero5_reg <= azero4_reg;
            a5_reg     <= a4_reg;
            hb5_reg    <= hb4_reg;

            hb2_reg    <= hb2_next;
            ac_reg     <= ac_next;
            cneg6_reg  <= cneg5_reg;
            azero6_reg <= azero5_reg;
            a6_reg     <= a5_reg;
            hb6_reg    <= hb5_reg;

            disc_reg   <= disc_next;
            a7_reg     <= a6_reg;
            hb7_reg    <= hb6_reg;
        end
    end

    assign ctl  = ctl7_reg;
    assign disc = disc_reg;
    assign hb   = hb7_reg;
    assign a    = a7_reg;

endmodule

`default_nettype wire

FILE: hdl/rsi_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module rsi_sqrt (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              adv,
    input  rsi_pkg::rsi_ctl_t                      ctl_in,
    input  wire logic        [rsi_pkg::DISC_W-1:0] disc_in,
    input  wire logic signed [rsi_pkg::HB_W-1:0]   hb_in,
    input  wire logic        [rsi_pkg::A_W-1:0]    a_in,
    output rsi_pkg::rsi_ctl_t                      ctl,
    output logic        [rsi_pkg::ROOT_W-1:0]      root,
    output logic signed [rsi_pkg::HB_W-1:0]        hb,
    output logic        [rsi_pkg::A_W-1:0]         a
);
    import rsi_pkg::*;

    localparam int STEPS = ROOT_W;

    // one root bit per stage, two radicand bits brought down each time
    rsi_ctl_t               ctl_reg  [STEPS];
    logic [DISC_W-1:0]      d_reg    [STEPS];
    logic [ROOT_W:0]        rem_reg  [STEPS];
    logic [ROOT_W-1:0]      root_reg [STEPS];
    logic signed [HB_W-1:0] hb_reg   [STEPS];
    logic [A_W-1:0]         a_reg    [STEPS];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        rsi_ctl_t               ctl_src;
        logic [DISC_W-1:0]      d_src;
        logic [ROOT_W:0]        rem_src;
        logic [ROOT_W-1:0]      root_src;
        logic signed [HB_W-1:0] hb_src;
        logic [A_W-1:0]         a_src;
        logic [SQ_REM_W-1:0]    rs;
        logic [SQ_REM_W-1:0]    trial;
        logic [SQ_REM_W-1:0]    diff;
        logic                   ge;
        logic [ROOT_W:0]        rem_next;
        logic [ROOT_W-1:0]      root_next;

        if (i == 0)
        begin : g_first
            assign ctl_src  = ctl_in;
            assign d_src    = disc_in;
            assign rem_src  = '0;
            assign root_src = '0;
            assign hb_src   = hb_in;
            assign a_src    = a_in;
        end
        else
        begin : g_rest
            assign ctl_src  = ctl_reg[i-1];
            assign d_src    = d_reg[i-1];
            assign rem_src  = rem_reg[i-1];
            assign root_src = root_reg[i-1];
            assign hb_src   = hb_reg[i-1];
            assign a_src    = a_reg[i-1];
        end

        always_comb
        begin
            rs        = {rem_src, d_src[DISC_W-1 -: 2]};
            trial     = {1'b0, root_src, 2'b01};
            diff      = rs - trial;
            ge        = (rs >= trial);
            rem_next  = ge ? diff[ROOT_W:0] : rs[ROOT_W:0];
            root_next = {root_src[ROOT_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[i] <= '0;
            else if (adv)
                ctl_reg[i] <= ctl_src;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_reg[i]    <= {d_src[DISC_W-3:0], 2'b00};
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                hb_reg[i]   <= hb_src;
                a_reg[i]    <= a_src;
            end
        end
    end

    assign ctl  = ctl_reg[STEPS-1];
    assign root = root_reg[STEPS-1];
    assign hb   = hb_reg[STEPS-1];
    assign a    = a_reg[STEPS-1];

endmodule

`default_nettype wire

FILE: hdl/rsi_div.sv
`timescale 1ns / 1ps
`default_nettype none

module rsi_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              adv,
    input  rsi_pkg::rsi_ctl_t                      ctl_in,
    input  wire logic        [rsi_pkg::ROOT_W-1:0] root_in,
    input  wire logic signed [rsi_pkg::HB_W-1:0]   hb_in,
    input  wire logic        [rsi_pkg::A_W-1:0]    a_in,
    output logic                                   res_vld,
    output logic        [1:0]                      status,
    output logic signed [rsi_pkg::DIST_W-1:0]      hit_dist,
    output logic                                   sat
);
    import rsi_pkg::*;

    // d1: sum = hb + s, so the numerator is -sum
    rsi_ctl_t                ctl1_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [A_W-1:0]          a1_reg;

    // d2: magnitude, scaled by the fraction bits
    rsi_ctl_t                ctl2_reg;
    logic [M_W-1:0]          m_reg;
    logic                    neg2_reg;
    logic [A_W-1:0]          a2_reg;

    // d3: overflow check and first partial remainder
    rsi_ctl_t                ctl3_reg;
    logic [A_W-1:0]          rem3_reg;
    logic [Q_W-1:0]          lo3_reg;
    logic                    ovf3_reg;
    logic                    neg3_reg;
    logic [A_W-1:0]          a3_reg;

    // quotient steps
    rsi_ctl_t                ctl_reg [Q_W];
    logic [A_W-1:0]          rem_reg [Q_W];
    logic [Q_W-1:0]          lo_reg  [Q_W];
    logic [Q_W-1:0]          q_reg   [Q_W];
    logic                    ovf_reg [Q_W];
    logic                    neg_reg [Q_W];
    logic [A_W-1:0]          a_reg   [Q_W];

    // final rounding
    logic                    vld_out_reg;
    logic [1:0]              status_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic                    sat_reg;
    logic [1:0]              status_next;
    logic [DIST_W-1:0]       dist_next;
    logic                    sat_next;

    logic signed [SUM_W-1:0] sum_next;
    logic [MAG_W-1:0]        mag_next;
    logic [HI_W-1:0]         hi;
    logic [Q_W:0]            qf;
    rsi_ctl_t                ctl_last;

    assign sum_next = SUM_W'(hb_in) + $signed(SUM_W'(root_in));
    assign mag_next = MAG_W'(sum_reg[SUM_W-1] ? -sum_reg : sum_reg);
    assign hi       = m_reg[M_W-1:Q_W];

    for (genvar j = 0; j < Q_W; j++)
    begin : g_step
        rsi_ctl_t       ctl_src;
        logic [A_W-1:0] rem_src;
        logic [Q_W-1:0] lo_src;
        logic [Q_W-1:0] q_src;
        logic           ovf_src;
        logic           neg_src;
        logic [A_W-1:0] a_src;
        logic [A_W:0]   rs;
        logic [A_W:0]   dv;
        logic [A_W:0]   diff;
        logic           ge;

        if (j == 0)
        begin : g_first
            assign ctl_src = ctl3_reg;
            assign rem_src = rem3_reg;
            assign lo_src  = lo3_reg;
            assign q_src   = '0;
            assign ovf_src = ovf3_reg;
            assign neg_src = neg3_reg;
            assign a_src   = a3_reg;
        end
        else
        begin : g_rest
            assign ctl_src = ctl_reg[j-1];
            assign rem_src = rem_reg[j-1];
            assign lo_src  = lo_reg[j-1];
            assign q_src   = q_reg[j-1];
            assign ovf_src = ovf_reg[j-1];
            assign neg_src = neg_reg[j-1];
            assign a_src   = a_reg[j-1];
        end

        always_comb
        begin
            rs   = {rem_src, lo_src[Q_W-1]};
            dv   = {1'b0, a_src};
            diff = rs - dv;
            ge   = (rs >= dv);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[j] <= '0;
            else if (adv)
                ctl_reg[j] <= ctl_src;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j] <= ge ? diff[A_W-1:0] : rs[A_W-1:0];
                lo_reg[j]  <= {lo_src[Q_W-2:0], 1'b0};
                q_reg[j]   <= {q_src[Q_W-2:0], ge};
                ovf_reg[j] <= ovf_src;
                neg_reg[j] <= neg_src;
                a_reg[j]   <= a_src;
            end
        end
    end

    assign ctl_last = ctl_reg[Q_W-1];

    // floor for negative quotients: bump the magnitude when a remainder is left
    always_comb
    begin
        qf = {1'b0, q_reg[Q_W-1]}
           + (Q_W+1)'(neg_reg[Q_W-1] && (rem_reg[Q_W-1] != '0));
        status_next = ctl_last.status;
        priority if (ctl_last.status != ST_HIT)
        begin
            dist_next = MINUS_ONE;
            sat_next  = 1'b0;
        end
        else if (neg_reg[Q_W-1])
        begin
            sat_next  = ovf_reg[Q_W-1] || (qf > {1'b0, DIST_MIN});
            dist_next = sat_next ? DIST_MIN : (DIST_W'(0) - qf[DIST_W-1:0]);
        end
        else
        begin
            sat_next  = ovf_reg[Q_W-1] || q_reg[Q_W-1][Q_W-1];
            dist_next = sat_next ? DIST_MAX : q_reg[Q_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg    <= '0;
            ctl2_reg    <= '0;
            ctl3_reg    <= '0;
            vld_out_reg <= 1'b0;
            status_reg  <= ST_HIT;
        end
        else if (adv)
        begin
            ctl1_reg    <= ctl_in;
            ctl2_reg    <= ctl1_reg;
            ctl3_reg    <= ctl2_reg;
            vld_out_reg <= ctl_last.vld;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg  <= sum_next;
            a1_reg   <= a_in;
            m_reg    <= {mag_next, {FRAC_BITS{1'b0}}};
            neg2_reg <= !sum_reg[SUM_W-1] && (sum_reg != '0);
            a2_reg   <= a1_reg;
            rem3_reg <= A_W'(hi);
            lo3_reg  <= m_reg[Q_W-1:0];
            ovf3_reg <= (A_W'(hi) >= a2_reg);
            neg3_reg <= neg2_reg;
            a3_reg   <= a2_reg;
            dist_reg <= dist_next;
            sat_reg  <= sat_next;
        end
    end

    assign res_vld  = vld_out_reg;
    assign status   = status_reg;
    assign hit_dist = $signed(dist_reg);
    assign sat      = sat_reg;

endmodule

`default_nettype wire

FILE: hdl/rsi_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "ray_sphere_intersect_macros.svh"

module rsi_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              ray_valid,
    input wire logic                              ray_stall,
    input wire logic                              res_valid,
    input wire logic                              res_stall,
    input wire logic        [1:0]                 hit_status,
    input wire logic signed [rsi_pkg::DIST_W-1:0] hit_distance,
    input wire logic                              distance_saturated
);
    import rsi_pkg::*;

    // stalled result word holds
    `RSI_ASSERT_NEXT(a_out_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(hit_distance) && $stable(hit_status) && $stable(distance_saturated))

    // input stalls only behind an untaken result
    `RSI_ASSERT_IMP(a_in_stall, clk, rst_n, ray_stall, res_valid && res_stall && (ray_valid || !ray_valid))

    // miss and zero direction report -1.0, never saturated
    `RSI_ASSERT_IMP(a_no_hit, clk, rst_n, res_valid && (hit_status != ST_HIT), (hit_distance == MINUS_ONE) && !distance_saturated)

    // saturation only on a hit, clamped to a range end
    `RSI_ASSERT_IMP(a_sat, clk, rst_n, res_valid && distance_saturated, (hit_status == ST_HIT) && ((hit_distance == DIST_MAX) || (hit_distance == DIST_MIN)))

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);

`default_nettype wire
